[rtl/bchc_pkg.sv]
// ----------------------------------------------------------------------------
// bchc_pkg
// Shared types, widths, register indexes and tracker codes for the button
// click and hold classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bchc_pkg;

    localparam int MASK_BITS            = 16;
    localparam int TIME_BITS            = 32;
    localparam int SINCE_BITS           = TIME_BITS + 1;
    localparam int EVENT_BITS           = 3;
    localparam int CFG_INDEX_BITS       = 3;
    localparam int HISTORY_BITS_DEFAULT = 16;

    // Item commands.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_DOUBLE_CLICK_ENABLE    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_INTERVAL_MS   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RISE_MASK              = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FALL_MASK              = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PRESS_TIME_MS          = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DOUBLE_CLICK_WINDOW_MS = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_TIME_MS           = 3'd6;

    // Configuration reset values.
    localparam logic                 RST_DOUBLE_CLICK_ENABLE    = 1'b0;
    localparam logic [MASK_BITS-1:0] RST_DEBOUNCE_INTERVAL_MS   = 16'd5;
    localparam logic [MASK_BITS-1:0] RST_RISE_MASK              = 16'h00FF;
    localparam logic [MASK_BITS-1:0] RST_FALL_MASK              = 16'hFF00;
    localparam logic [MASK_BITS-1:0] RST_PRESS_TIME_MS          = 16'd500;
    localparam logic [MASK_BITS-1:0] RST_DOUBLE_CLICK_WINDOW_MS = 16'd250;
    localparam logic [MASK_BITS-1:0] RST_HOLD_TIME_MS           = 16'd1000;

    // Tracker and report codes.
    localparam logic [EVENT_BITS-1:0] TR_OPEN       = 3'd0;
    localparam logic [EVENT_BITS-1:0] TR_CLOSED     = 3'd1;
    localparam logic [EVENT_BITS-1:0] TR_CLICKED    = 3'd2;
    localparam logic [EVENT_BITS-1:0] TR_DOUBLE     = 3'd3;
    localparam logic [EVENT_BITS-1:0] TR_PRESSED    = 3'd4;
    localparam logic [EVENT_BITS-1:0] TR_HELD       = 3'd5;
    localparam logic [EVENT_BITS-1:0] TR_CLICK_HELD = 3'd6;
    localparam logic [EVENT_BITS-1:0] TR_RELEASED   = 3'd7;

    typedef struct packed {
        logic                 double_click_enable;
        logic [MASK_BITS-1:0] debounce_interval_ms;
        logic [MASK_BITS-1:0] rise_mask;
        logic [MASK_BITS-1:0] fall_mask;
        logic [MASK_BITS-1:0] press_time_ms;
        logic [MASK_BITS-1:0] double_click_window_ms;
        logic [MASK_BITS-1:0] hold_time_ms;
    } cfg_t;

    // Debouncer status after the current item: level and the signed time
    // since the last level change (two's complement).
    typedef struct packed {
        logic                  level_down;
        logic [SINCE_BITS-1:0] since;
    } deb_status_t;

endpackage

`default_nettype wire

[rtl/button_click_hold_classifier.sv]
// ----------------------------------------------------------------------------
// button_click_hold_classifier: debounced click, double click and hold detector
// Items pass the input register, then the single update stage into the result register.
// Throughput: one item per cycle while no finished result waits under out_stall.
// Reset: rst_n clears history, level, tracker and report at once and returns the
// configuration registers to their default values.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_hold_classifier #(
    parameter int HISTORY_BITS = bchc_pkg::HISTORY_BITS_DEFAULT
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // Input item channel.
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire                                  command,
    input  wire                                  raw_sample,
    input  wire  [bchc_pkg::TIME_BITS-1:0]       now_ms,
    // Result channel.
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output logic [bchc_pkg::EVENT_BITS-1:0]      reported_event,
    output logic                                 debounced_down,
    // Configuration write channel.
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [bchc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire  [bchc_pkg::MASK_BITS-1:0]       cfg_data
);
    import bchc_pkg::*;

    // ------------------------------------------------------------------------
    // Configuration registers. The port never pushes back, so every write
    // transfer completes in the cycle it is offered. Unused indexes are
    // dropped by the decoder.
    // ------------------------------------------------------------------------
    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DOUBLE_CLICK_ENABLE:    cfg_next.double_click_enable    = cfg_data[0];
                REG_DEBOUNCE_INTERVAL_MS:   cfg_next.debounce_interval_ms   = cfg_data;
                REG_RISE_MASK:              cfg_next.rise_mask              = cfg_data;
                REG_FALL_MASK:              cfg_next.fall_mask              = cfg_data;
                REG_PRESS_TIME_MS:          cfg_next.press_time_ms          = cfg_data;
                REG_DOUBLE_CLICK_WINDOW_MS: cfg_next.double_click_window_ms = cfg_data;
                REG_HOLD_TIME_MS:           cfg_next.hold_time_ms           = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.double_click_enable    <= RST_DOUBLE_CLICK_ENABLE;
            cfg_reg.debounce_interval_ms   <= RST_DEBOUNCE_INTERVAL_MS;
            cfg_reg.rise_mask              <= RST_RISE_MASK;
            cfg_reg.fall_mask              <= RST_FALL_MASK;
            cfg_reg.press_time_ms          <= RST_PRESS_TIME_MS;
            cfg_reg.double_click_window_ms <= RST_DOUBLE_CLICK_WINDOW_MS;
            cfg_reg.hold_time_ms           <= RST_HOLD_TIME_MS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------------
    // Input register. An item sitting here is processed in the cycle it
    // moves into the result register; the state registers update on that
    // same edge, so the next item already sees the new state. The stage
    // only holds when a finished result is still waiting downstream.
    // ------------------------------------------------------------------------
    logic                 stage_valid_reg;
    logic                 stage_valid_next;
    logic                 stage_command_reg;
    logic                 stage_sample_reg;
    logic [TIME_BITS-1:0] stage_now_reg;
    logic                 advance;
    logic                 in_accept;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [EVENT_BITS-1:0] out_event_reg;
    logic                  out_level_reg;

    assign advance          = stage_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall         = stage_valid_reg && !advance;
    assign in_accept        = in_valid && !in_stall;
    assign stage_valid_next = in_accept || (stage_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_command_reg <= command;
            stage_sample_reg  <= raw_sample;
            stage_now_reg     <= now_ms;
        end
    end

    // ------------------------------------------------------------------------
    // Update logic: debouncer feeding the tracker, both gated by the stage
    // moving forward.
    // ------------------------------------------------------------------------
    logic                  tick_en;
    logic                  read_en;
    deb_status_t           deb_status;
    logic [EVENT_BITS-1:0] report_next;
    logic [EVENT_BITS-1:0] tracker_state;
    logic [EVENT_BITS-1:0] report_state;

    assign tick_en = advance && (stage_command_reg == CMD_TICK);
    assign read_en = advance && (stage_command_reg == CMD_READ);

    bchc_debounce #(
        .HISTORY_BITS (HISTORY_BITS)
    ) u_debounce (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick_en (tick_en),
        .sample  (stage_sample_reg),
        .now_ms  (stage_now_reg),
        .cfg     (cfg_reg),
        .status  (deb_status)
    );

    bchc_tracker u_tracker (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_en       (tick_en),
        .read_en       (read_en),
        .cfg           (cfg_reg),
        .deb           (deb_status),
        .report_next   (report_next),
        .tracker_state (tracker_state),
        .report_state  (report_state)
    );

    // ------------------------------------------------------------------------
    // Result register. It holds a result until its transfer completes, and
    // is refilled in the same cycle that the old result leaves.
    // ------------------------------------------------------------------------
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_event_reg <= report_next;
            out_level_reg <= deb_status.level_down;
        end
    end

    assign out_valid      = out_valid_reg;
    assign reported_event = out_event_reg;
    assign debounced_down = out_level_reg;

`ifndef SYNTHESIS
    // A report never carries the closed or released tracker codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (reported_event != TR_CLOSED && reported_event != TR_RELEASED))
        else $error("report carries a tracker-only code");

    // The input side only stalls while an item occupies the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> stage_valid_reg)
        else $error("input stalled with an empty input register");

    // While the tracker sits in a hold state the report names that hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tracker_state == TR_HELD || tracker_state == TR_CLICK_HELD)
            |-> (report_state == tracker_state))
        else $error("hold state without matching report");

    // State only moves when an item leaves the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(advance) |-> ($stable(tracker_state) && $stable(report_state)))
        else $error("tracker changed without an item");
`endif

endmodule

`default_nettype wire

[rtl/bchc_debounce.sv]
// ----------------------------------------------------------------------------
// bchc_debounce
// Sample history, debounced level and time of the last level change.
// ----------------------------------------------------------------------------
`default_nettype none

module bchc_debounce #(
    parameter int HISTORY_BITS = bchc_pkg::HISTORY_BITS_DEFAULT
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                tick_en,
    input  wire                                sample,
    input  wire  [bchc_pkg::TIME_BITS-1:0]     now_ms,
    input  wire  bchc_pkg::cfg_t               cfg,
    output bchc_pkg::deb_status_t              status
);
    import bchc_pkg::*;

    localparam int EXT_BITS = (HISTORY_BITS > MASK_BITS) ? HISTORY_BITS : MASK_BITS;

    logic [HISTORY_BITS-1:0] history_reg;
    logic [HISTORY_BITS-1:0] history_next;
    logic                    level_reg;
    logic                    level_next;
    logic [TIME_BITS-1:0]    last_change_reg;
    logic [TIME_BITS-1:0]    last_change_next;

    logic [EXT_BITS-1:0]  hist_ext;
    logic [EXT_BITS-1:0]  rise_ext;
    logic [EXT_BITS-1:0]  fall_ext;
    logic [TIME_BITS-1:0] elapsed;
    logic                 interval_met;
    logic                 rise_match;
    logic                 fall_match;

    assign history_next = {history_reg[HISTORY_BITS-2:0], sample};

    // Mask bits beyond the history see zero history bits.
    assign hist_ext = EXT_BITS'(history_next);
    assign rise_ext = EXT_BITS'(cfg.rise_mask);
    assign fall_ext = EXT_BITS'(cfg.fall_mask);

    assign rise_match = ((hist_ext & rise_ext) == rise_ext);
    assign fall_match = ((hist_ext & ~fall_ext) == '0);

    assign elapsed      = now_ms - last_change_reg;
    assign interval_met = (now_ms >= last_change_reg)
                       && (elapsed >= TIME_BITS'(cfg.debounce_interval_ms));

    always_comb
    begin
        level_next       = level_reg;
        last_change_next = last_change_reg;
        if (tick_en && interval_met)
        begin
            if (!level_reg && rise_match)
            begin
                level_next       = 1'b1;
                last_change_next = now_ms;
            end
            else if (level_reg && fall_match)
            begin
                level_next       = 1'b0;
                last_change_next = now_ms;
            end
        end
    end

    assign status.level_down = level_next;
    assign status.since      = {1'b0, now_ms} - {1'b0, last_change_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg     <= '0;
            level_reg       <= 1'b0;
            last_change_reg <= '0;
        end
        else if (tick_en)
        begin
            history_reg     <= history_next;
            level_reg       <= level_next;
            last_change_reg <= last_change_next;
        end
    end

endmodule

`default_nettype wire

[rtl/bchc_tracker.sv]
// ----------------------------------------------------------------------------
// bchc_tracker
// Eight-state click and hold tracker with latched report and read handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module bchc_tracker (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 tick_en,
    input  wire                                 read_en,
    input  wire  bchc_pkg::cfg_t                cfg,
    input  wire  bchc_pkg::deb_status_t         deb,
    output logic [bchc_pkg::EVENT_BITS-1:0]     report_next,
    output logic [bchc_pkg::EVENT_BITS-1:0]     tracker_state,
    output logic [bchc_pkg::EVENT_BITS-1:0]     report_state
);
    import bchc_pkg::*;

    logic [EVENT_BITS-1:0] tracker_reg;
    logic [EVENT_BITS-1:0] tracker_next;
    logic [EVENT_BITS-1:0] report_reg;
    logic                  taken_reg;
    logic                  taken_next;

    logic signed [SINCE_BITS-1:0] since;
    logic signed [SINCE_BITS-1:0] press_s;
    logic signed [SINCE_BITS-1:0] window_s;
    logic signed [MASK_BITS:0]    hold_less_press;
    logic signed [SINCE_BITS-1:0] hold_less_press_s;

    assign since    = $signed(deb.since);
    assign press_s  = $signed({{(SINCE_BITS-MASK_BITS){1'b0}}, cfg.press_time_ms});
    assign window_s = $signed({{(SINCE_BITS-MASK_BITS){1'b0}}, cfg.double_click_window_ms});
    assign hold_less_press = $signed({1'b0, cfg.hold_time_ms})
                           - $signed({1'b0, cfg.press_time_ms});
    assign hold_less_press_s = $signed({{(SINCE_BITS-MASK_BITS-1){hold_less_press[MASK_BITS]}},
                                        hold_less_press});

    always_comb
    begin
        tracker_next = tracker_reg;
        report_next  = report_reg;
        taken_next   = taken_reg;
        if (tick_en)
        begin
            unique case (tracker_reg)
                TR_OPEN:
                begin
                    report_next = TR_OPEN;
                    if (deb.level_down)
                    begin
                        tracker_next = TR_CLOSED;
                    end
                end
                TR_CLOSED:
                begin
                    if (!deb.level_down)
                    begin
                        if (!cfg.double_click_enable)
                        begin
                            report_next  = TR_CLICKED;
                            tracker_next = TR_RELEASED;
                            taken_next   = 1'b0;
                        end
                        else
                        begin
                            tracker_next = TR_CLICKED;
                        end
                    end
                    else if (since >= press_s)
                    begin
                        tracker_next = TR_PRESSED;
                    end
                end
                TR_CLICKED:
                begin
                    if (deb.level_down)
                    begin
                        if (since < window_s)
                        begin
                            tracker_next = TR_DOUBLE;
                        end
                    end
                    else if (since >= window_s)
                    begin
                        report_next  = TR_CLICKED;
                        tracker_next = TR_RELEASED;
                        taken_next   = 1'b0;
                    end
                end
                TR_DOUBLE:
                begin
                    if (since >= window_s)
                    begin
                        taken_next = 1'b0;
                        if (deb.level_down)
                        begin
                            report_next  = TR_CLICK_HELD;
                            tracker_next = TR_CLICK_HELD;
                        end
                        else
                        begin
                            report_next  = TR_DOUBLE;
                            tracker_next = TR_RELEASED;
                        end
                    end
                end
                TR_PRESSED:
                begin
                    if (!deb.level_down)
                    begin
                        report_next  = TR_PRESSED;
                        tracker_next = TR_RELEASED;
                        taken_next   = 1'b0;
                    end
                    else if (since >= hold_less_press_s)
                    begin
                        report_next  = TR_HELD;
                        tracker_next = TR_HELD;
                        taken_next   = 1'b0;
                    end
                end
                TR_HELD, TR_CLICK_HELD:
                begin
                    if (!deb.level_down)
                    begin
                        tracker_next = TR_RELEASED;
                    end
                end
                TR_RELEASED:
                begin
                    if (taken_reg)
                    begin
                        tracker_next = TR_OPEN;
                        report_next  = TR_OPEN;
                    end
                end
                default:
                begin
                    tracker_next = TR_OPEN;
                end
            endcase
        end
        else if (read_en && (tracker_reg == TR_RELEASED))
        begin
            taken_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracker_reg <= TR_OPEN;
            report_reg  <= TR_OPEN;
            taken_reg   <= 1'b0;
        end
        else
        begin
            tracker_reg <= tracker_next;
            report_reg  <= report_next;
            taken_reg   <= taken_next;
        end
    end

    assign tracker_state = tracker_reg;
    assign report_state  = report_reg;

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for button_click_hold_classifier
// Drives service ticks and report reads through the valid/stall item channel,
// predicts the debounced level and the latched click/double/press/hold report
// for every transfer, and checks each result in order while both channels
// idle and stall at random and the configuration is swept between phases.
// ----------------------------------------------------------------------------

module testbench;

    import bchc_pkg::*;

    // Run control constants.
    localparam int HIST_W           = HISTORY_BITS_DEFAULT;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 2000;

    // Register index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

    // Receiver stall patterns. The receiver switches between them on its own
    // schedule so that stalls land on every phase of a gesture.
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SPARSE,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_t;

    // One result transfer: the latched report and the debounced level.
    typedef struct packed {
        logic [EVENT_BITS-1:0] gesture;
        logic                  level;
    } button_report_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals of the block. Every input starts at a known
    // value at time zero.
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid   = 1'b0;
    logic                      in_stall;
    logic                      command    = CMD_TICK;
    logic                      raw_sample = 1'b0;
    logic [TIME_BITS-1:0]      now_ms     = '0;
    logic                      out_valid;
    logic                      out_stall  = 1'b0;
    logic [EVENT_BITS-1:0]     reported_event;
    logic                      debounced_down;
    logic                      cfg_valid  = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index  = '0;
    logic [MASK_BITS-1:0]      cfg_data   = '0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    button_click_hold_classifier uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .raw_sample     (raw_sample),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .reported_event (reported_event),
        .debounced_down (debounced_down),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predictor state. This mirrors the block: the configuration as it was
    // last written, the raw sample history, the debounced level with the time
    // of its last change, the gesture tracker and the latched report.
    // ------------------------------------------------------------------------
    cfg_t model_cfg = '{
        RST_DOUBLE_CLICK_ENABLE,
        RST_DEBOUNCE_INTERVAL_MS,
        RST_RISE_MASK,
        RST_FALL_MASK,
        RST_PRESS_TIME_MS,
        RST_DOUBLE_CLICK_WINDOW_MS,
        RST_HOLD_TIME_MS
    };

    logic [HIST_W-1:0]     btn_history      = '0;
    logic                  btn_level        = 1'b0;
    logic [TIME_BITS-1:0]  level_changed_at = '0;
    logic [EVENT_BITS-1:0] tracker          = TR_OPEN;
    logic [EVENT_BITS-1:0] latched_report   = TR_OPEN;
    logic                  report_acked     = 1'b0;

    // Results still owed by the block, oldest first.
    button_report_t expected_reports[$];
    button_report_t oldest_report;

    int mismatches   = 0;
    int quiet_cycles = 0;

    // Stimulus bookkeeping shared by the test tasks.
    logic [TIME_BITS-1:0] clock_ms     = '0;
    int                   step_lo      = 1;
    int                   step_hi      = 1;
    int                   items_sent   = 0;
    int                   burst_left   = 0;
    bit                   sender_gaps  = 1'b1;
    bit                   hold_request = 1'b0;

    // Latching a report always restarts the not-yet-read status of the report.
    function automatic void latch_report(input logic [EVENT_BITS-1:0] report,
                                         input logic [EVENT_BITS-1:0] next);
        latched_report = report;
        tracker        = next;
        report_acked   = 1'b0;
    endfunction

    // Advance the predictor by one item and return the result it should cause.
    // All time comparisons of the tracker are done on signed 64-bit values so
    // that a timestamp older than the last level change gives a negative age.
    function automatic button_report_t classify_item(input logic                 cmd,
                                                     input logic                 sample,
                                                     input logic [TIME_BITS-1:0] now);
        button_report_t result;
        longint         since;
        longint         now_l;
        longint         changed_l;
        longint         press_l;
        longint         window_l;
        longint         hold_l;

        if (cmd == CMD_TICK)
        begin
            btn_history = {btn_history[HIST_W-2:0], sample};

            // The level may only move once the debounce interval has passed
            // since the last change, and never while time runs backwards.
            if (now >= level_changed_at &&
                (now - level_changed_at) >= TIME_BITS'(model_cfg.debounce_interval_ms))
            begin
                if (!btn_level)
                begin
                    if ((btn_history & model_cfg.rise_mask) == model_cfg.rise_mask)
                    begin
                        btn_level        = 1'b1;
                        level_changed_at = now;
                    end
                end
                else if ((btn_history | model_cfg.fall_mask) == model_cfg.fall_mask)
                begin
                    btn_level        = 1'b0;
                    level_changed_at = now;
                end
            end

            now_l     = longint'(now);
            changed_l = longint'(level_changed_at);
            since     = now_l - changed_l;
            press_l   = longint'(model_cfg.press_time_ms);
            window_l  = longint'(model_cfg.double_click_window_ms);
            hold_l    = longint'(model_cfg.hold_time_ms);

            case (tracker)
                TR_OPEN:
                begin
                    latched_report = TR_OPEN;
                    if (btn_level)
                        tracker = TR_CLOSED;
                end
                TR_CLOSED:
                begin
                    if (!btn_level)
                    begin
                        if (!model_cfg.double_click_enable)
                            latch_report(TR_CLICKED, TR_RELEASED);
                        else
                            tracker = TR_CLICKED;
                    end
                    else if (since >= press_l)
                    begin
                        tracker = TR_PRESSED;
                    end
                end
                TR_CLICKED:
                begin
                    if (btn_level)
                    begin
                        if (since < window_l)
                            tracker = TR_DOUBLE;
                    end
                    else if (since >= window_l)
                    begin
                        latch_report(TR_CLICKED, TR_RELEASED);
                    end
                end
                TR_DOUBLE:
                begin
                    if (since >= window_l)
                    begin
                        if (btn_level)
                            latch_report(TR_CLICK_HELD, TR_CLICK_HELD);
                        else
                            latch_report(TR_DOUBLE, TR_RELEASED);
                    end
                end
                TR_PRESSED:
                begin
                    // The hold threshold after a press is the difference of
                    // two registers and may be zero or negative.
                    if (!btn_level)
                        latch_report(TR_PRESSED, TR_RELEASED);
                    else if (since >= hold_l - press_l)
                        latch_report(TR_HELD, TR_HELD);
                end
                TR_HELD, TR_CLICK_HELD:
                begin
                    if (!btn_level)
                        tracker = TR_RELEASED;
                end
                default:
                begin
                    // Released: a read since the report was latched lets the
                    // tracker start over.
                    if (report_acked)
                    begin
                        tracker        = TR_OPEN;
                        latched_report = TR_OPEN;
                    end
                end
            endcase
        end
        else if (tracker == TR_RELEASED)
        begin
            // A read only acknowledges a report once the gesture is over.
            report_acked = 1'b1;
        end

        result.gesture = latched_report;
        result.level   = btn_level;
        return result;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, before the block's
    // own updates of that edge take effect. The result is checked before the
    // next prediction is queued, and configuration transfers update the
    // predictor's copy of the registers.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result transfer with nothing expected: reported_event %0d debounced_down %0b",
                             $time, reported_event, debounced_down);
                end
                else
                begin
                    oldest_report = expected_reports.pop_front();
                    if (reported_event !== oldest_report.gesture)
                    begin
                        mismatches++;
                        $display("%0t: reported_event mismatch, expected %0d actual %0d",
                                 $time, oldest_report.gesture, reported_event);
                    end
                    if (debounced_down !== oldest_report.level)
                    begin
                        mismatches++;
                        $display("%0t: debounced_down mismatch, expected %0b actual %0b",
                                 $time, oldest_report.level, debounced_down);
                    end
                end
            end

            if (in_valid && !in_stall)
                expected_reports.push_back(classify_item(command, raw_sample, now_ms));

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DOUBLE_CLICK_ENABLE:    model_cfg.double_click_enable    = cfg_data[0];
                    REG_DEBOUNCE_INTERVAL_MS:   model_cfg.debounce_interval_ms   = cfg_data;
                    REG_RISE_MASK:              model_cfg.rise_mask              = cfg_data;
                    REG_FALL_MASK:              model_cfg.fall_mask              = cfg_data;
                    REG_PRESS_TIME_MS:          model_cfg.press_time_ms          = cfg_data;
                    REG_DOUBLE_CLICK_WINDOW_MS: model_cfg.double_click_window_ms = cfg_data;
                    REG_HOLD_TIME_MS:           model_cfg.hold_time_ms           = cfg_data;
                    default:                    ;
                endcase
            end

            // Watchdog: any transfer on any channel counts as progress. A long
            // run of cycles without one means the block has locked up.
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver. It drives out_stall at the falling edge, moving between
    // stall patterns on a schedule of its own. When asked, it holds off for a
    // long stretch so that the block fills up and stalls its input.
    // ------------------------------------------------------------------------
    initial
    begin
        stall_mode_t stall_mode;
        int          stall_tick;

        stall_mode = STALL_NONE;
        stall_tick = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_stall = 1'b1;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            if (stall_tick == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                stall_tick = $urandom_range(20, 120);
            end
            else
            begin
                stall_tick--;
            end
            case (stall_mode)
                STALL_NONE:     out_stall = 1'b0;
                STALL_SPARSE:   out_stall = ($urandom_range(0, 3) == 0);
                STALL_PERIODIC: out_stall = ((stall_tick % 5) < 2);
                default:        out_stall = 1'($urandom_range(0, 1));
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks. Items go out in bursts of random length with random gaps
    // between them while sender_gaps is set, back to back otherwise. The
    // payload is driven at the falling edge and held until the transfer.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic                 cmd,
                             input logic                 sample,
                             input logic [TIME_BITS-1:0] now);
        int gap;

        if (sender_gaps && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(1, 6);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   = 1'b1;
        command    = cmd;
        raw_sample = sample;
        now_ms     = now;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    // A service tick a random number of milliseconds after the previous one.
    task automatic send_tick(input logic sample);
        clock_ms = clock_ms + $urandom_range(step_lo, step_hi);
        send_item(CMD_TICK, sample, clock_ms);
    endtask

    // A read; its sample and timestamp are ignored, so they carry random bits.
    task automatic send_read();
        send_item(CMD_READ, 1'($urandom_range(0, 1)), $urandom);
    endtask

    // Stop offering items and wait until every owed result has arrived.
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_reports.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [MASK_BITS-1:0]      data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Registers are only rewritten once the block has gone quiet.
    task automatic program_config(input logic                 dbl_enable,
                                  input logic [MASK_BITS-1:0] debounce,
                                  input logic [MASK_BITS-1:0] rise,
                                  input logic [MASK_BITS-1:0] fall,
                                  input logic [MASK_BITS-1:0] press,
                                  input logic [MASK_BITS-1:0] window,
                                  input logic [MASK_BITS-1:0] hold);
        drain_results();
        write_reg(REG_DOUBLE_CLICK_ENABLE, {{(MASK_BITS-1){1'b0}}, dbl_enable});
        write_reg(REG_DEBOUNCE_INTERVAL_MS, debounce);
        write_reg(REG_RISE_MASK, rise);
        write_reg(REG_FALL_MASK, fall);
        write_reg(REG_PRESS_TIME_MS, press);
        write_reg(REG_DOUBLE_CLICK_WINDOW_MS, window);
        write_reg(REG_HOLD_TIME_MS, hold);
    endtask

    // Well-formed button gestures with random content: contact bounce at both
    // edges, a closure of random length, then an open stretch that is either
    // short (a chance of a second click) or long. Reads are mixed in so that
    // reports get acknowledged, and now and then a tick arrives with a stale
    // timestamp or a stray bit breaks up the closure.
    task automatic run_gestures(input int count,
                                input int press_lo, input int press_hi,
                                input int gap_lo,   input int gap_hi);
        int stop_at;
        int len;
        int k;

        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(0, 3)) send_tick(1'($urandom_range(0, 1)));
            len = $urandom_range(press_lo, press_hi);
            for (k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_read();
                send_tick($urandom_range(0, 15) != 0);
            end
            repeat ($urandom_range(0, 3)) send_tick(1'($urandom_range(0, 1)));
            if ($urandom_range(0, 9) == 0)
                send_item(CMD_TICK, 1'($urandom_range(0, 1)),
                          clock_ms - $urandom_range(1, 50));
            len = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4)
                                              : $urandom_range(gap_lo, gap_hi);
            for (k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_read();
                send_tick(1'b0);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test tasks.
    // ------------------------------------------------------------------------

    // Field extremes, both commands, reads before and after release, time
    // going backwards, a hold time below the press time and a write to the
    // unused register index, with one-sample debouncing so every step shows.
    task automatic test_directed_cases();
        sender_gaps = 1'b0;
        // At reset configuration: a read while open and the timestamp extremes.
        send_item(CMD_READ, 1'b1, 32'hFFFF_FFFF);
        send_item(CMD_TICK, 1'b1, 32'h0000_0000);
        send_item(CMD_TICK, 1'b0, 32'hFFFF_FFFF);

        program_config(1'b0, 16'd0, 16'h0001, 16'hFFFE, 16'd10, 16'd5, 16'd3);
        write_reg(REG_UNUSED, 16'hFFFF);

        send_item(CMD_READ, 1'b0, 32'h0000_0000);
        send_item(CMD_TICK, 1'b1, 32'd100);          // level rises, closed
        send_item(CMD_TICK, 1'b1, 32'd50);           // timestamp behind the change
        send_item(CMD_READ, 1'b1, 32'd0);            // read while not released
        send_item(CMD_TICK, 1'b1, 32'd110);          // long press
        send_item(CMD_TICK, 1'b1, 32'd111);          // hold below press: held at once
        send_item(CMD_TICK, 1'b0, 32'd112);          // release
        send_item(CMD_READ, 1'b0, 32'hFFFF_FFFF);    // acknowledge
        send_item(CMD_TICK, 1'b0, 32'd113);          // back to open
        send_item(CMD_TICK, 1'b1, 32'd0);            // backwards, level must not rise
        send_item(CMD_TICK, 1'b1, 32'd200);
        send_item(CMD_TICK, 1'b0, 32'd201);          // single click reported
        send_item(CMD_TICK, 1'b0, 32'hFFFF_FFFF);    // released, not yet read
        send_item(CMD_READ, 1'b1, 32'd5);
        send_item(CMD_TICK, 1'b0, 32'd300);
        clock_ms = 32'd1000;
    endtask

    task automatic test_click_and_double_click();
        program_config(1'b1, 16'd2, 16'h0007, 16'hFFF8, 16'd30, 16'd20, 16'd60);
        step_lo = 1;
        step_hi = 3;
        run_gestures(400, 3, 30, 3, 25);
    endtask

    // Reset values for the timing, with ticks tens of milliseconds apart so
    // that press and hold thresholds are reached, first without and then
    // with double-click detection.
    task automatic test_long_press_and_hold();
        program_config(RST_DOUBLE_CLICK_ENABLE, RST_DEBOUNCE_INTERVAL_MS, RST_RISE_MASK,
                       RST_FALL_MASK, RST_PRESS_TIME_MS, RST_DOUBLE_CLICK_WINDOW_MS,
                       RST_HOLD_TIME_MS);
        step_lo = 15;
        step_hi = 40;
        run_gestures(200, 10, 70, 10, 30);
        program_config(1'b1, RST_DEBOUNCE_INTERVAL_MS, RST_RISE_MASK, RST_FALL_MASK,
                       RST_PRESS_TIME_MS, RST_DOUBLE_CLICK_WINDOW_MS, RST_HOLD_TIME_MS);
        run_gestures(150, 10, 70, 10, 30);
    endtask

    // Hold time of zero, well below the press time. The clock also jumps far
    // ahead so that the upper timestamp bits are exercised on ticks.
    task automatic test_hold_shorter_than_press();
        program_config(1'b1, 16'd0, 16'h0003, 16'hFFFC, 16'd12, 16'd8, 16'd0);
        clock_ms = clock_ms + 32'h7000_0000;
        step_lo  = 1;
        step_hi  = 4;
        run_gestures(300, 2, 15, 2, 12);
    endtask

    // The receiver holds off for a long stretch while items keep coming back
    // to back, so the block must fill up and push back on its input.
    task automatic test_output_backpressure();
        int i;

        drain_results();
        sender_gaps  = 1'b0;
        hold_request = 1'b1;
        for (i = 0; i < 150; i++)
        begin
            if ((i % 9) == 8)
                send_read();
            else
                send_tick((i % 24) < 12);
        end
    endtask

    // Register extremes: first masks that let the level follow every tick at
    // the longest debounce and thresholds, then masks that need a full history
    // of ones or zeros with every threshold at zero.
    task automatic test_mask_extremes();
        program_config(1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        step_lo = 1000;
        step_hi = 40000;
        run_gestures(200, 1, 8, 1, 8);
        program_config(1'b0, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        step_lo = 1;
        step_hi = 2;
        run_gestures(200, 10, 40, 10, 40);
    endtask

    // Unstructured items: random commands, samples and timestamps anywhere in
    // the 32-bit range, including wrap-around and stale times.
    task automatic test_random_noise();
        int i;

        for (i = 0; i < 150; i++)
        begin
            if ((i % 30) == 0)
                sender_gaps = 1'($urandom_range(0, 1));
            send_item(($urandom_range(0, 1) == 0) ? CMD_TICK : CMD_READ,
                      1'($urandom_range(0, 1)), $urandom);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence. Reset is applied once; then the test tasks run in
    // turn, the last results are collected and the verdict is printed.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_click_and_double_click();
        test_long_press_and_hold();
        test_hold_shorter_than_press();
        test_output_backpressure();
        test_mask_extremes();
        test_random_noise();

        // Collect the owed results, then keep running so that a stray extra
        // result would still be caught.
        drain_results();
        repeat (8) @(negedge clk);
        if (expected_reports.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time, expected_reports.size());
        end

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
